>>> src/binary_window_all_ones_detect_unit_macros.svh
// assertion macros shared by the binary window detector rtl
`ifndef BINARY_WINDOW_ALL_ONES_DETECT_UNIT_MACROS_SVH
`define BINARY_WINDOW_ALL_ONES_DETECT_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define BWAD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define BWAD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BWAD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define BWAD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> src/bwad_pkg.sv
// shared constants and types of the binary window detector
`default_nettype none
package bwad_pkg;
    localparam int IMG_MAX_W_DEF = 1024;
    localparam int IMG_MAX_H_DEF = 1024;

    localparam int PIX_W     = 8;
    localparam int REG_W     = 11;
    localparam int COORD_W   = 10;
    localparam int WIN_BITS  = 9;
    localparam int LS_W      = 2;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam int M_DATA_W  = 24;

    localparam logic [PIX_W-1:0] SET_CHAR      = 8'd49;
    localparam logic [REG_W-1:0] DIM_RST       = 11'd1024;
    localparam int               DIM_MIN       = 3;
    localparam int               INTERIOR_MIN  = 2;

    localparam logic REG_IDX_WIDTH  = 1'b0;
    localparam logic REG_IDX_HEIGHT = 1'b1;

    // item held between the input register stage and the window stage
    typedef struct packed {
        logic               pix;
        logic               interior;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } t_stage;

    // window stage control back to the scan stage
    typedef struct packed {
        logic            adv;
        logic            wr_en;
        logic [LS_W-1:0] wr_data;
    } t_win_ctl;
endpackage
`default_nettype wire

>>> src/binary_window_all_ones_detect_unit.sv
// Binary 3x3 erosion detector over a raster stream of image characters.
// One pixel is taken per clock unless input is held back; the result of a
// pixel that completes an all-set window passes the input register stage and
// is then registered in the output register, carrying the window center's
// row and column (interior centers only). Two line stores share one 2-bit
// wide RAM of IMG_MAX_W entries with one read and one write per pixel. After
// reset a clearing pass writes every RAM entry, one entry a cycle, during
// which s_axis_tready stays low; register writes are taken throughout. When
// a result waits in the output register and is not taken, input is held back
// only if the pixel in flight also completes a result.
`default_nettype none
module binary_window_all_ones_detect_unit #(
    parameter int IMG_MAX_W = bwad_pkg::IMG_MAX_W_DEF,
    parameter int IMG_MAX_H = bwad_pkg::IMG_MAX_H_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [bwad_pkg::APB_AW-1:0]      paddr,
    input  wire logic [bwad_pkg::APB_DW-1:0]      pwdata,
    output logic      [bwad_pkg::APB_DW-1:0]      prdata,
    output logic                                  pready,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [bwad_pkg::PIX_W-1:0]       s_axis_tdata,  // [7:0] pixel_char
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic      [bwad_pkg::M_DATA_W-1:0]    m_axis_tdata   // [9:0] center_row,
                                                                 // [19:10] center_col
);
    import bwad_pkg::*;

    localparam int LP_CW = $clog2(IMG_MAX_W);
    localparam int LP_WW = $clog2(IMG_MAX_W + 1);
    localparam int LP_HW = $clog2(IMG_MAX_H + 1);

    logic [LP_WW-1:0]   eff_w;
    logic [LP_HW-1:0]   eff_h;
    t_win_ctl           win_ctl;
    logic               rd_en;
    logic [LP_CW-1:0]   rd_addr;
    logic [LS_W-1:0]    rd_data;
    logic               wr_en;
    logic [LP_CW-1:0]   wr_addr;
    logic [LS_W-1:0]    wr_data;
    logic               st_valid;
    t_stage             st;
    logic [COORD_W-1:0] res_row;
    logic [COORD_W-1:0] res_col;

    bwad_cfg #(
        .IMG_MAX_W (IMG_MAX_W),
        .IMG_MAX_H (IMG_MAX_H)
    ) u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_eff_w   (eff_w),
        .o_eff_h   (eff_h)
    );

    bwad_scan #(
        .IMG_MAX_W (IMG_MAX_W),
        .IMG_MAX_H (IMG_MAX_H)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_eff_w    (eff_w),
        .i_eff_h    (eff_h),
        .i_s_valid  (s_axis_tvalid),
        .i_s_data   (s_axis_tdata),
        .o_s_ready  (s_axis_tready),
        .i_win      (win_ctl),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_st_valid (st_valid),
        .o_st       (st)
    );

    bwad_ram #(
        .WIDTH (LS_W),
        .DEPTH (IMG_MAX_W)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    bwad_win u_win (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_st_valid (st_valid),
        .i_st       (st),
        .i_rd_data  (rd_data),
        .o_win      (win_ctl),
        .o_m_valid  (m_axis_tvalid),
        .i_m_ready  (m_axis_tready),
        .o_row      (res_row),
        .o_col      (res_col)
    );

    assign m_axis_tdata = M_DATA_W'({res_col, res_row});
endmodule
`default_nettype wire

>>> src/bwad_ram.sv
// generic single write port ram with registered read
`default_nettype none
module bwad_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule
`default_nettype wire

>>> src/bwad_cfg.sv
// apb register file for image size, with clamped effective dimensions
`default_nettype none
module bwad_cfg #(
    parameter int IMG_MAX_W = bwad_pkg::IMG_MAX_W_DEF,
    parameter int IMG_MAX_H = bwad_pkg::IMG_MAX_H_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_psel,
    input  wire logic                          i_penable,
    input  wire logic                          i_pwrite,
    input  wire logic [bwad_pkg::APB_AW-1:0]   i_paddr,
    input  wire logic [bwad_pkg::APB_DW-1:0]   i_pwdata,
    output logic      [bwad_pkg::APB_DW-1:0]   o_prdata,
    output logic                               o_pready,
    output logic      [$clog2(IMG_MAX_W+1)-1:0]  o_eff_w,
    output logic      [$clog2(IMG_MAX_H+1)-1:0]  o_eff_h
);
    import bwad_pkg::*;

    localparam int LP_WW = $clog2(IMG_MAX_W + 1);
    localparam int LP_HW = $clog2(IMG_MAX_H + 1);
    localparam int LP_XW = (REG_W > LP_WW) ? REG_W : LP_WW;
    localparam int LP_YW = (REG_W > LP_HW) ? REG_W : LP_HW;

    logic [REG_W-1:0] r_width;
    logic [REG_W-1:0] r_height;
    logic             wr_req;
    logic [LP_XW-1:0] w_ext;
    logic [LP_YW-1:0] h_ext;

    assign wr_req   = i_psel && i_penable && i_pwrite && o_pready;
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_RST;
            r_height <= DIM_RST;
        end else if (wr_req) begin
            case (i_paddr[2])
                REG_IDX_WIDTH:  r_width  <= i_pwdata[REG_W-1:0];
                REG_IDX_HEIGHT: r_height <= i_pwdata[REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_paddr[2])
            REG_IDX_WIDTH:  o_prdata = APB_DW'(r_width);
            REG_IDX_HEIGHT: o_prdata = APB_DW'(r_height);
            default:        o_prdata = '0;
        endcase
    end

    // saturate to [3, max]
    assign w_ext = LP_XW'(r_width);
    assign h_ext = LP_YW'(r_height);

    always_comb begin
        if (w_ext < LP_XW'(DIM_MIN)) begin
            o_eff_w = LP_WW'(DIM_MIN);
        end else if (w_ext > LP_XW'(IMG_MAX_W)) begin
            o_eff_w = LP_WW'(IMG_MAX_W);
        end else begin
            o_eff_w = LP_WW'(w_ext);
        end
        if (h_ext < LP_YW'(DIM_MIN)) begin
            o_eff_h = LP_HW'(DIM_MIN);
        end else if (h_ext > LP_YW'(IMG_MAX_H)) begin
            o_eff_h = LP_HW'(IMG_MAX_H);
        end else begin
            o_eff_h = LP_HW'(h_ext);
        end
    end
endmodule
`default_nettype wire

>>> src/bwad_scan.sv
// input register stage: raster position, line store access and clearing sweep
`default_nettype none
`include "binary_window_all_ones_detect_unit_macros.svh"
module bwad_scan #(
    parameter int IMG_MAX_W = bwad_pkg::IMG_MAX_W_DEF,
    parameter int IMG_MAX_H = bwad_pkg::IMG_MAX_H_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic [$clog2(IMG_MAX_W+1)-1:0]   i_eff_w,
    input  wire logic [$clog2(IMG_MAX_H+1)-1:0]   i_eff_h,
    input  wire logic                             i_s_valid,
    input  wire logic [bwad_pkg::PIX_W-1:0]       i_s_data,
    output logic                                  o_s_ready,
    input  wire bwad_pkg::t_win_ctl               i_win,
    output logic                                  o_rd_en,
    output logic      [$clog2(IMG_MAX_W)-1:0]     o_rd_addr,
    output logic                                  o_wr_en,
    output logic      [$clog2(IMG_MAX_W)-1:0]     o_wr_addr,
    output logic      [bwad_pkg::LS_W-1:0]        o_wr_data,
    output logic                                  o_st_valid,
    output bwad_pkg::t_stage                      o_st
);
    import bwad_pkg::*;

    localparam int LP_CW = $clog2(IMG_MAX_W);
    localparam int LP_RW = $clog2(IMG_MAX_H);
    localparam int LP_WW = $clog2(IMG_MAX_W + 1);
    localparam int LP_HW = $clog2(IMG_MAX_H + 1);

    logic [LP_CW-1:0] r_col;
    logic [LP_RW-1:0] r_row;
    logic [LP_CW-1:0] n_col;
    logic [LP_RW-1:0] n_row;
    logic [LP_CW-1:0] r_addr;
    logic [LP_CW-1:0] r_clr_cnt;
    logic             r_clr_done;
    logic             r_st_valid;
    t_stage           r_st;
    logic             acc;
    logic [LP_WW-1:0] col_inc;
    logic [LP_HW-1:0] row_inc;
    logic [LP_RW-1:0] row_m1;
    logic [LP_CW-1:0] col_m1;

    assign o_s_ready = r_clr_done && i_win.adv;
    assign acc       = i_s_valid && o_s_ready;

    assign col_inc = LP_WW'(r_col) + LP_WW'(1);
    assign row_inc = LP_HW'(r_row) + LP_HW'(1);
    assign row_m1  = r_row - LP_RW'(1);
    assign col_m1  = r_col - LP_CW'(1);

    // a column at or past the width wraps, also after a width change
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (col_inc >= i_eff_w) begin
            n_col = '0;
            n_row = (row_inc >= i_eff_h) ? '0 : LP_RW'(row_inc);
        end else begin
            n_col = LP_CW'(col_inc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_st_valid <= 1'b0;
            r_clr_cnt  <= '0;
            r_clr_done <= 1'b0;
        end else begin
            if (acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (i_win.adv) begin
                r_st_valid <= acc;
            end
            if (!r_clr_done) begin
                r_clr_cnt <= r_clr_cnt + LP_CW'(1);
                if (r_clr_cnt == LP_CW'(IMG_MAX_W - 1)) begin
                    r_clr_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_addr      <= r_col;
            r_st.pix    <= (i_s_data == SET_CHAR);
            r_st.interior <= (r_row >= LP_RW'(INTERIOR_MIN)) &&
                             (r_col >= LP_CW'(INTERIOR_MIN));
            r_st.row    <= COORD_W'(row_m1);
            r_st.col    <= COORD_W'(col_m1);
        end
    end

    // line store entry: bit 0 row-2, bit 1 row-1
    assign o_rd_en   = acc;
    assign o_rd_addr = r_col;
    assign o_wr_en   = !r_clr_done || i_win.wr_en;
    assign o_wr_addr = r_clr_done ? r_addr : r_clr_cnt;
    assign o_wr_data = r_clr_done ? i_win.wr_data : '0;

    assign o_st_valid = r_st_valid;
    assign o_st       = r_st;

    `BWAD_ASSERT_NEXT(a_st_capture, i_clk, i_rst_n, acc, r_st_valid,
        "accepted request did not reach the window stage")
    `BWAD_ASSERT_NEXT(a_st_hold, i_clk, i_rst_n, r_st_valid && !i_win.adv,
        r_st_valid && $stable(r_addr), "stalled item lost its line store address")
    `BWAD_ASSERT_IMPL(a_clr_excl, i_clk, i_rst_n, !r_clr_done, !r_st_valid && !i_win.wr_en,
        "pixel write during line store clearing")
endmodule
`default_nettype wire

>>> src/bwad_win.sv
// window stage: 3x3 window shift, all-ones check and result register
`default_nettype none
`include "binary_window_all_ones_detect_unit_macros.svh"
module bwad_win (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_st_valid,
    input  wire bwad_pkg::t_stage              i_st,
    input  wire logic [bwad_pkg::LS_W-1:0]     i_rd_data,
    output bwad_pkg::t_win_ctl                 o_win,
    output logic                               o_m_valid,
    input  wire logic                          i_m_ready,
    output logic      [bwad_pkg::COORD_W-1:0]  o_row,
    output logic      [bwad_pkg::COORD_W-1:0]  o_col
);
    import bwad_pkg::*;

    logic [WIN_BITS-1:0] r_win;
    logic [WIN_BITS-1:0] n_win;
    logic                r_o_valid;
    logic [COORD_W-1:0]  r_o_row;
    logic [COORD_W-1:0]  r_o_col;
    logic [2:0]          column;
    logic                hit;
    logic                stall;
    logic                step;

    // column bits: upper, middle, current from low to high
    assign column = {i_st.pix, i_rd_data[1], i_rd_data[0]};
    assign n_win  = {r_win[WIN_BITS-4:0], column};
    assign hit    = i_st_valid && i_st.interior && (&n_win);
    // only a pending result with a full output register that is not taken holds the stage
    assign stall  = hit && r_o_valid && !i_m_ready;
    assign step   = i_st_valid && !stall;

    assign o_win.adv     = !stall;
    assign o_win.wr_en   = step;
    assign o_win.wr_data = {i_st.pix, i_rd_data[1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (step) begin
                r_win <= n_win;
            end
            if (step && hit) begin
                r_o_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && hit) begin
            r_o_row <= i_st.row;
            r_o_col <= i_st.col;
        end
    end

    assign o_m_valid = r_o_valid;
    assign o_row     = r_o_row;
    assign o_col     = r_o_col;

    `BWAD_ASSERT_NEXT(a_win_hold, i_clk, i_rst_n, stall, $stable(r_win),
        "window moved while its item was stalled")
    `BWAD_ASSERT_IMPL(a_res_taken, i_clk, i_rst_n, $fell(r_o_valid), $past(i_m_ready),
        "result dropped without being taken")
endmodule
`default_nettype wire
